/* rtl/core/sbl_pkg.sv */
package sbl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int OP_W         = 2;
	localparam int CNT_W        = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;

	// one strobe per controller step
	typedef struct packed {
		logic capture;
		logic start;
		logic pop;
		logic walk;
		logic link1;
		logic link2;
		logic rm1;
		logic rm2;
		logic finish;
	} sbl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            free_none;
		logic            head_none;
		logic            next_none;
		logic            hit_ge;
		logic            hit_eq;
	} sbl_stat_t;

endpackage

/* rtl/core/sbl_ram.sv */
module sbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/sbl_ctrl.sv */
module sbl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  sbl_pkg::sbl_stat_t stat,
	output sbl_pkg::sbl_cmd_t  cmd
);
	import sbl_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_START = 9'b000000010,
		S_POP   = 9'b000000100,
		S_WALK  = 9'b000001000,
		S_LINK1 = 9'b000010000,
		S_LINK2 = 9'b000100000,
		S_RM1   = 9'b001000000,
		S_RM2   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.start   = (state_q == S_START);
		cmd.pop     = (state_q == S_POP);
		cmd.walk    = (state_q == S_WALK);
		cmd.link1   = (state_q == S_LINK1);
		cmd.link2   = (state_q == S_LINK2);
		cmd.rm1     = (state_q == S_RM1);
		cmd.rm2     = (state_q == S_RM2);
		cmd.finish  = (state_q == S_DONE) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				if (stat.op == OP_INSERT) begin
					state_d = stat.free_none ? S_DONE : S_POP;
				end else if (stat.op == OP_REMOVE || stat.op == OP_COUNT) begin
					state_d = stat.head_none ? S_DONE : S_WALK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP: begin
				state_d = stat.head_none ? S_LINK1 : S_WALK;
			end
			S_WALK: begin
				if (stat.op == OP_INSERT) begin
					if (stat.hit_ge || stat.next_none) state_d = S_LINK1;
				end else if (stat.op == OP_REMOVE) begin
					if (stat.hit_eq) state_d = S_RM1;
					else if (stat.next_none) state_d = S_DONE;
				end else begin
					if (stat.next_none) state_d = S_DONE;
				end
			end
			S_LINK1: state_d = S_LINK2;
			S_LINK2: state_d = S_DONE;
			S_RM1:   state_d = S_RM2;
			S_RM2:   state_d = S_DONE;
			S_DONE: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/sbl_datapath.sv */
module sbl_datapath #(
	parameter int CAPACITY = sbl_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sbl_pkg::OP_W-1:0]     operation,
	input  logic signed [sbl_pkg::DATA_W-1:0] value,
	input  sbl_pkg::sbl_cmd_t            cmd,
	output sbl_pkg::sbl_stat_t           stat,
	output logic                         ok,
	output logic [sbl_pkg::CNT_W-1:0]    occurrences,
	output logic [sbl_pkg::CNT_W-1:0]    size
);
	import sbl_pkg::*;

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [SW-1:0] NONE = SW'(CAPACITY);

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [SW-1:0]     head_q, free_q, count_q, fill_q;
	logic [SW-1:0]     cur_q, n_q, a_q, b_q, occ_q, rd_addr_q;
	logic              ok_q;

	logic [SW-1:0]     raddr, rd_next, next_ram;
	logic [SW-1:0]     prev_rd;
	logic [DATA_W-1:0] elem_rd;

	logic              nx_we, pv_we;
	logic [SW-1:0]     nx_wa, nx_wd, pv_wa, pv_wd;
	logic              a_slot, b_slot;

	assign a_slot = a_q < NONE;
	assign b_slot = b_q < NONE;

	// slots at or above the fill mark were never written: they still chain to i+1
	assign rd_next = (rd_addr_q >= fill_q) ? rd_addr_q + 1'b1 : next_ram;

	always_comb begin
		raddr = cur_q;
		if (cmd.start) raddr = (op_q == OP_INSERT) ? free_q : head_q;
		else if (cmd.pop) raddr = head_q;
		else if (cmd.walk) raddr = rd_next;
	end

	always_comb begin
		nx_we = 1'b0; nx_wa = n_q; nx_wd = a_q;
		pv_we = 1'b0; pv_wa = n_q; pv_wd = b_q;
		if (cmd.link1) begin
			nx_we = 1'b1; pv_we = 1'b1;
		end else if (cmd.link2) begin
			nx_we = b_slot; nx_wa = b_q; nx_wd = n_q;
			pv_we = a_slot; pv_wa = a_q; pv_wd = n_q;
		end else if (cmd.rm1) begin
			nx_we = 1'b1; nx_wd = free_q;
			pv_we = a_slot; pv_wa = a_q; pv_wd = b_q;
		end else if (cmd.rm2) begin
			nx_we = b_slot; nx_wa = b_q; nx_wd = a_q;
		end
	end

	sbl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa[AW-1:0]), .wdata(nx_wd),
		.raddr(raddr[AW-1:0]), .rdata(next_ram)
	);

	sbl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa[AW-1:0]), .wdata(pv_wd),
		.raddr(raddr[AW-1:0]), .rdata(prev_rd)
	);

	sbl_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_elem (
		.clk(clk), .we(cmd.pop), .waddr(n_q[AW-1:0]), .wdata(val_q),
		.raddr(raddr[AW-1:0]), .rdata(elem_rd)
	);

	always_comb begin
		stat.op        = op_q;
		stat.free_none = !(free_q < NONE);
		stat.head_none = !(head_q < NONE);
		stat.next_none = !(rd_next < NONE);
		stat.hit_ge    = $signed(val_q) >= $signed(elem_rd);
		stat.hit_eq    = val_q == elem_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NONE;
			free_q  <= '0;
			count_q <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.pop) begin
				free_q <= rd_next;
				if (rd_addr_q >= fill_q) fill_q <= rd_addr_q + 1'b1;
			end
			if (cmd.link2) begin
				if (!b_slot) head_q <= n_q;
				count_q <= count_q + 1'b1;
			end
			if (cmd.rm1) begin
				free_q <= n_q;
				if (!b_slot) head_q <= a_q;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		rd_addr_q <= raddr;
		if (cmd.capture) begin
			op_q  <= operation;
			val_q <= value;
			ok_q  <= 1'b0;
			occ_q <= '0;
		end
		if (cmd.start) begin
			n_q   <= free_q;
			cur_q <= head_q;
		end
		if (cmd.pop) begin
			cur_q <= head_q;
			a_q   <= NONE;
			b_q   <= NONE;
		end
		if (cmd.walk) begin
			cur_q <= rd_next;
			if (op_q == OP_INSERT) begin
				a_q <= stat.hit_ge ? cur_q : NONE;
				b_q <= stat.hit_ge ? prev_rd : cur_q;
			end else if (op_q == OP_REMOVE) begin
				n_q <= cur_q;
				a_q <= rd_next;
				b_q <= prev_rd;
			end else if (stat.hit_eq) begin
				occ_q <= occ_q + 1'b1;
				ok_q  <= 1'b1;
			end
		end
		if (cmd.link2 || cmd.rm1) ok_q <= 1'b1;
		if (cmd.finish) begin
			ok          <= ok_q;
			occurrences <= CNT_W'(occ_q);
			size        <= CNT_W'(count_q);
		end
	end

endmodule

/* rtl/core/sorted_bag_linked_table_core.sv */
// Sorted multiset of signed 32-bit values, kept as a doubly linked list in
// descending order with a free list of slots.
// Input channel (in_valid / in_stall, operation, value): a transaction is
// taken when in_valid is high and in_stall low. operation selects insert,
// remove one occurrence or count occurrences.
// Output channel (out_valid / out_stall, ok, occurrences, size): one result
// transaction per input transaction, in order.
// A transaction that searches the list walks it through one read port per
// table, one node per cycle. One transaction is worked at a time.
// in_stall is high while a transaction is being worked; a new one is taken
// while the previous result still waits in the output register.
// Reset empties the list at once: no clearing pass, never-used slots are
// tracked by a fill mark. When the receiver stalls the result holds, and the
// block finishes its next transaction and waits before delivering it.
module sorted_bag_linked_table_core #(
	parameter int CAPACITY = sbl_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sbl_pkg::OP_W-1:0]          operation,
	input  logic signed [sbl_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              ok,
	output logic [sbl_pkg::CNT_W-1:0]         occurrences,
	output logic [sbl_pkg::CNT_W-1:0]         size
);
	import sbl_pkg::*;

	sbl_cmd_t  cmd;
	sbl_stat_t stat;

	// sequence the walk and relink steps
	sbl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	// link tables, list pointers and result register
	sbl_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.operation(operation), .value(value),
		.cmd(cmd), .stat(stat),
		.ok(ok), .occurrences(occurrences), .size(size)
	);

endmodule

/* rtl/core/sbl_checker.sv */
module sbl_checker #(
	parameter int CAPACITY = sbl_pkg::CAPACITY_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [sbl_pkg::OP_W-1:0]          operation,
	input logic signed [sbl_pkg::DATA_W-1:0] value,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              ok,
	input logic [sbl_pkg::CNT_W-1:0]         occurrences,
	input logic [sbl_pkg::CNT_W-1:0]         size
);
	import sbl_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input valid dropped while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(size))
		else $error("stalled result changed");

	a_occ_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && occurrences != '0 |-> ok)
		else $error("occurrences without ok");

	a_occ_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> CAPACITY > 127 || occurrences <= size)
		else $error("more occurrences than stored values");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

endmodule

bind sorted_bag_linked_table_core sbl_checker #(.CAPACITY(CAPACITY)) u_sbl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.operation(operation), .value(value), .out_valid(out_valid),
	.out_stall(out_stall), .ok(ok), .occurrences(occurrences), .size(size)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import sbl_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] val;
		bit                drain;	// hold off until every result has arrived
	} bag_txn_t;

	typedef struct {
		logic             ok;
		logic [CNT_W-1:0] occ;
		logic [CNT_W-1:0] size;
	} bag_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic                     ok;
	logic [CNT_W-1:0]         occurrences;
	logic [CNT_W-1:0]         size;

	sorted_bag_linked_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .occurrences(occurrences), .size(size)
	);

	// Pending stimulus, expected results, and the bag predictor's own state.
	bag_txn_t          pending_q[$];
	bag_result_t       bag_expect_q[$];
	logic [DATA_W-1:0] bag_vals[$];	// stored values, kept in descending signed order
	int                fail_count;
	bit                stim_done;
	bit                quiet;	// set for the last part of the run: no idling

	// Predict one transaction. The list order is descending and a duplicate goes
	// before its equals, but only multiplicities are visible, so a sorted queue
	// captures everything the outputs can show.
	function automatic bag_result_t bag_predict(logic [OP_W-1:0] op, logic [DATA_W-1:0] v);
		bag_result_t r;
		int pos;
		int n;
		r.ok = 1'b0;
		r.occ = '0;
		pos = -1;
		n = 0;
		case (op)
			OP_INSERT: begin
				if (bag_vals.size() < SLOTS) begin
					pos = bag_vals.size();
					for (int i = 0; i < bag_vals.size(); i++)
						if ($signed(v) >= $signed(bag_vals[i])) begin
							pos = i;
							break;
						end
					bag_vals.insert(pos, v);
					r.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				for (int i = 0; i < bag_vals.size(); i++)
					if (bag_vals[i] == v) begin
						pos = i;
						break;
					end
				if (pos >= 0) begin
					bag_vals.delete(pos);
					r.ok = 1'b1;
				end
			end
			OP_COUNT: begin
				foreach (bag_vals[i])
					if (bag_vals[i] == v)
						n++;
				r.occ = n[CNT_W-1:0];
				r.ok = (n != 0);
			end
			default: ;	// unused code: nothing changes
		endcase
		r.size = CNT_W'(bag_vals.size());
		return r;
	endfunction

	function automatic void push_txn(logic [OP_W-1:0] op, logic [DATA_W-1:0] v, bit drain = 0);
		bag_txn_t t;
		t.op = op;
		t.val = v;
		t.drain = drain;
		pending_q.push_back(t);
	endfunction

	// Draw a value from a small pool so duplicates and hits are common,
	// with occasional fully random values to toggle every bit.
	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] pool[8];
		pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
			32'h1, 32'd10, 32'h5555_AAAA, 32'hAAAA_5555};
		if ($urandom_range(0, 3) == 0)
			return $urandom();
		return pool[$urandom_range(0, 7)];
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// Build the stimulus: directed corners, then random phases.
	initial begin
		int mode;
		logic [OP_W-1:0] op;
		fail_count = 0;
		stim_done = 0;
		quiet = 0;
		// empty-bag corners: remove and count of an absent value
		push_txn(OP_REMOVE, 32'h0);
		push_txn(OP_COUNT, 32'h8000_0000);
		// field extremes, duplicates, and ordering around zero
		push_txn(OP_INSERT, 32'h8000_0000);
		push_txn(OP_INSERT, 32'h7FFF_FFFF);
		push_txn(OP_INSERT, 32'hFFFF_FFFF);
		push_txn(OP_INSERT, 32'h0);
		push_txn(OP_INSERT, 32'h7FFF_FFFF);
		push_txn(OP_COUNT, 32'h7FFF_FFFF);
		push_txn(OP_COUNT, 32'h8000_0000);
		push_txn(OP_REMOVE, 32'h1234_5678);	// absent value, state unchanged
		push_txn(OP_REMOVE, 32'h7FFF_FFFF);
		push_txn(OP_COUNT, 32'h7FFF_FFFF);
		push_txn(OP_REMOVE, 32'h8000_0000);	// tail removal
		push_txn(OP_REMOVE, 32'h7FFF_FFFF);	// head removal
		push_txn(2'd3, 32'hFFFF_FFFF);	// unused code
		push_txn(2'd3, 32'h0);
		push_txn(OP_COUNT, 32'hFFFF_FFFF, 1);
		// fill to capacity, with rejected inserts beyond it, then removes of 10
		for (int i = 0; i < SLOTS; i++)
			push_txn(OP_INSERT, (i % 3 == 0) ? 32'd10 : $urandom());
		push_txn(OP_INSERT, 32'd10);	// table full
		push_txn(OP_COUNT, 32'd10);
		for (int i = 0; i < 20; i++)
			push_txn(OP_REMOVE, 32'd10);
		// random phases: grow-biased, shrink-biased and balanced mixes
		for (int i = 0; i < 1200; i++) begin
			mode = (i / 150) % 3;
			case ($urandom_range(0, 19))
				0: op = 2'd3;
				1, 2, 3, 4, 5: op = OP_COUNT;
				default: op = ($urandom_range(0, 9) < (mode == 0 ? 7 : mode == 1 ? 3 : 5))
					? OP_INSERT : OP_REMOVE;
			endcase
			push_txn(op, pick_value(), (i == 400 || i == 900));
		end
		stim_done = 1;
	end

	// Driver: present the next pending transaction, advance on acceptance.
	int  src_gap;
	bit  holding;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			value <= '0;
			src_gap <= 0;
			holding <= 0;
		end else begin
			bit      take;
			bag_txn_t t;
			take = 0;
			if (in_valid && !in_stall) begin
				bag_expect_q.push_back(bag_predict(operation, value));
				take = 1;
			end
			if (in_valid && !take) begin
				// hold a stalled payload
			end else if (src_gap > 0) begin
				in_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (pending_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_q[0].drain && !holding) begin
				in_valid <= 1'b0;
				holding <= 1;
			end else if (holding && (bag_expect_q.size() != 0 || take)) begin
				in_valid <= 1'b0;
			end else begin
				holding <= 0;
				t = pending_q.pop_front();
				if (pending_q.size() < 150)
					quiet = 1;
				if (!quiet && take && $urandom_range(0, 5) == 0) begin
					// idle burst: put the item back and wait
					pending_q.push_front(t);
					in_valid <= 1'b0;
					src_gap <= $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b1;
					operation <= t.op;
					value <= t.val;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest prediction.
	int sink_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_gap <= 0;
		end else begin
			bag_result_t e;
			if (out_valid && !out_stall) begin
				if (bag_expect_q.size() == 0) begin
					$display("%0t: unexpected result ok=%0b occurrences=%0d size=%0d",
						$time, ok, occurrences, size);
					fail_count++;
				end else begin
					e = bag_expect_q.pop_front();
					if (ok !== e.ok) begin
						$display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
						fail_count++;
					end
					if (occurrences !== e.occ) begin
						$display("%0t: occurrences expected %0d actual %0d",
							$time, e.occ, occurrences);
						fail_count++;
					end
					if (size !== e.size) begin
						$display("%0t: size expected %0d actual %0d", $time, e.size, size);
						fail_count++;
					end
				end
			end
			// stall in bursts, none once the run is in its quiet tail
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
			end else if (!quiet && out_stall == 1'b0 && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				sink_gap <= $urandom_range(0, 7);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// End of run: all stimulus taken, all results in, then a short settle.
	initial begin
		wait (stim_done);
		wait (pending_q.size() == 0 && !in_valid && bag_expect_q.size() == 0);
		repeat (SLOTS + 20) @(posedge clk);
		if (fail_count == 0 && bag_expect_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
